// File: design/capm_pkg.sv
// Shared types, constants and the control microprogram of the attitude mixer.
// Depends on nothing; every other design file imports it.
package capm_pkg;

   // field widths
   localparam int RATE_W  = 18;
   localparam int ACCEL_W = 17;
   localparam int STICK_W = 12;
   localparam int PULSE_W = 11;
   localparam int GAIN_W  = 24;
   localparam int STATE_W = 24;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;
   localparam int STEP_W  = 6;
   localparam int OP_W    = 4;
   localparam int MUL_W   = 32;
   localparam int INT_FRAC = 13;

   // register indexes
   localparam logic [2:0] REG_ANGLE_P = 3'd0;
   localparam logic [2:0] REG_ANGLE_I = 3'd1;
   localparam logic [2:0] REG_ANGLE_D = 3'd2;
   localparam logic [2:0] REG_RATE_P  = 3'd3;
   localparam logic [2:0] REG_RATE_I  = 3'd4;
   localparam logic [2:0] REG_RATE_D  = 3'd5;
   localparam logic [2:0] REG_HOVER   = 3'd6;
   localparam logic [2:0] REG_MAX     = 3'd7;

   // register reset values
   localparam logic [GAIN_W-1:0]  RST_ANGLE_P = 24'd196608;
   localparam logic [GAIN_W-1:0]  RST_ANGLE_I = 24'd6554;
   localparam logic [GAIN_W-1:0]  RST_ANGLE_D = 24'd0;
   localparam logic [GAIN_W-1:0]  RST_RATE_P  = 24'd229376;
   localparam logic [GAIN_W-1:0]  RST_RATE_I  = 24'd5243;
   localparam logic [GAIN_W-1:0]  RST_RATE_D  = 24'd131;
   localparam logic [PULSE_W-1:0] RST_HOVER   = 11'd1460;
   localparam logic [PULSE_W-1:0] RST_MAX     = 11'd1850;

   // arithmetic constants
   localparam logic signed [MUL_W-1:0] ALPHA_Q16   = 32'sd62915;
   localparam logic signed [MUL_W-1:0] BETA_Q16    = 32'sd2621;
   localparam logic signed [MUL_W-1:0] DT_Q24      = 32'sd67109;
   localparam logic signed [MUL_W-1:0] HALF_DT_Q24 = 32'sd33554;
   localparam logic [STICK_W-1:0]      ARM_LEVEL   = 12'd1500;
   localparam logic [PULSE_W-1:0]      PULSE_MIN   = 11'd1000;
   localparam logic signed [63:0]      S24_MAX     = 64'sd8388607;
   localparam logic signed [63:0]      S24_MIN     = -64'sd8388608;
   localparam logic signed [63:0]      INT_LIM     = 64'sd3276800;

   // micro-op codes
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_F_MUL_RATE  = 4'd0;
   localparam op_type OP_F_SUM       = 4'd1;
   localparam op_type OP_F_MUL_ALPHA = 4'd2;
   localparam op_type OP_F_MUL_BETA  = 4'd3;
   localparam op_type OP_F_WRITE     = 4'd4;
   localparam op_type OP_ARM         = 4'd5;
   localparam op_type OP_SP_MUL      = 4'd6;
   localparam op_type OP_ERR         = 4'd7;
   localparam op_type OP_MUL_P       = 4'd8;
   localparam op_type OP_P_STEP      = 4'd9;
   localparam op_type OP_Q_STEP      = 4'd10;
   localparam op_type OP_MUL_I       = 4'd11;
   localparam op_type OP_INT_STEP    = 4'd12;
   localparam op_type OP_D_STEP      = 4'd13;
   localparam op_type OP_OUT_STEP    = 4'd14;
   localparam op_type OP_END         = 4'd15;

   localparam logic [STEP_W-1:0] STEP_END = 6'd45;

   typedef struct packed {
      logic                active;
      op_type              op;
      logic                axis;    // 0 pitch, 1 roll
      logic                inner;   // 0 angle loop, 1 rate loop
      logic                jump;    // jump to target when disarmed
      logic [STEP_W-1:0]   target;
   } ctrl_type;

   typedef struct packed {
      logic disarmed;
      logic out_busy;
   } stat_type;

   typedef struct packed {
      logic [GAIN_W-1:0]  angle_p;
      logic [GAIN_W-1:0]  angle_i;
      logic [GAIN_W-1:0]  angle_d;
      logic [GAIN_W-1:0]  rate_p;
      logic [GAIN_W-1:0]  rate_i;
      logic [GAIN_W-1:0]  rate_d;
      logic [PULSE_W-1:0] hover;
      logic [PULSE_W-1:0] max_pulse;
   } cfg_type;

   typedef struct packed {
      logic signed [RATE_W-1:0]  pitch_rate;
      logic signed [RATE_W-1:0]  roll_rate;
      logic signed [ACCEL_W-1:0] accel_pitch;
      logic signed [ACCEL_W-1:0] accel_roll;
      logic [STICK_W-1:0]        roll_stick;
      logic [STICK_W-1:0]        pitch_stick;
      logic [STICK_W-1:0]        arm_switch;
   } req_item_type;

   typedef struct packed {
      logic [PULSE_W-1:0] front_left;
      logic [PULSE_W-1:0] front_right;
      logic [PULSE_W-1:0] back_left;
      logic [PULSE_W-1:0] back_right;
      logic               armed;
   } rsp_item_type;

   function automatic ctrl_type cw(input op_type op, input logic axis, input logic inner);
      ctrl_type w;
      w.active = 1'b1;
      w.op     = op;
      w.axis   = axis;
      w.inner  = inner;
      w.jump   = 1'b0;
      w.target = '0;
      return w;
   endfunction

   // control store: filter both axes, arm check, four PIDs, output
   function automatic ctrl_type rom_word(input logic [STEP_W-1:0] step);
      ctrl_type w;
      case (step)
         6'd0:  w = cw(OP_F_MUL_RATE,  1'b0, 1'b0);
         6'd1:  w = cw(OP_F_SUM,       1'b0, 1'b0);
         6'd2:  w = cw(OP_F_MUL_ALPHA, 1'b0, 1'b0);
         6'd3:  w = cw(OP_F_MUL_BETA,  1'b0, 1'b0);
         6'd4:  w = cw(OP_F_WRITE,     1'b0, 1'b0);
         6'd5:  w = cw(OP_F_MUL_RATE,  1'b1, 1'b0);
         6'd6:  w = cw(OP_F_SUM,       1'b1, 1'b0);
         6'd7:  w = cw(OP_F_MUL_ALPHA, 1'b1, 1'b0);
         6'd8:  w = cw(OP_F_MUL_BETA,  1'b1, 1'b0);
         6'd9:  w = cw(OP_F_WRITE,     1'b1, 1'b0);
         6'd10: begin
            w = cw(OP_ARM, 1'b0, 1'b0);
            w.jump   = 1'b1;
            w.target = STEP_END;
         end
         // pitch angle loop
         6'd11: w = cw(OP_SP_MUL,   1'b0, 1'b0);
         6'd12: w = cw(OP_ERR,      1'b0, 1'b0);
         6'd13: w = cw(OP_MUL_P,    1'b0, 1'b0);
         6'd14: w = cw(OP_P_STEP,   1'b0, 1'b0);
         6'd15: w = cw(OP_Q_STEP,   1'b0, 1'b0);
         6'd16: w = cw(OP_MUL_I,    1'b0, 1'b0);
         6'd17: w = cw(OP_INT_STEP, 1'b0, 1'b0);
         6'd18: w = cw(OP_D_STEP,   1'b0, 1'b0);
         6'd19: w = cw(OP_OUT_STEP, 1'b0, 1'b0);
         // pitch rate loop
         6'd20: w = cw(OP_ERR,      1'b0, 1'b1);
         6'd21: w = cw(OP_MUL_P,    1'b0, 1'b1);
         6'd22: w = cw(OP_P_STEP,   1'b0, 1'b1);
         6'd23: w = cw(OP_Q_STEP,   1'b0, 1'b1);
         6'd24: w = cw(OP_MUL_I,    1'b0, 1'b1);
         6'd25: w = cw(OP_INT_STEP, 1'b0, 1'b1);
         6'd26: w = cw(OP_D_STEP,   1'b0, 1'b1);
         6'd27: w = cw(OP_OUT_STEP, 1'b0, 1'b1);
         // roll angle loop
         6'd28: w = cw(OP_SP_MUL,   1'b1, 1'b0);
         6'd29: w = cw(OP_ERR,      1'b1, 1'b0);
         6'd30: w = cw(OP_MUL_P,    1'b1, 1'b0);
         6'd31: w = cw(OP_P_STEP,   1'b1, 1'b0);
         6'd32: w = cw(OP_Q_STEP,   1'b1, 1'b0);
         6'd33: w = cw(OP_MUL_I,    1'b1, 1'b0);
         6'd34: w = cw(OP_INT_STEP, 1'b1, 1'b0);
         6'd35: w = cw(OP_D_STEP,   1'b1, 1'b0);
         6'd36: w = cw(OP_OUT_STEP, 1'b1, 1'b0);
         // roll rate loop
         6'd37: w = cw(OP_ERR,      1'b1, 1'b1);
         6'd38: w = cw(OP_MUL_P,    1'b1, 1'b1);
         6'd39: w = cw(OP_P_STEP,   1'b1, 1'b1);
         6'd40: w = cw(OP_Q_STEP,   1'b1, 1'b1);
         6'd41: w = cw(OP_MUL_I,    1'b1, 1'b1);
         6'd42: w = cw(OP_INT_STEP, 1'b1, 1'b1);
         6'd43: w = cw(OP_D_STEP,   1'b1, 1'b1);
         6'd44: w = cw(OP_OUT_STEP, 1'b1, 1'b1);
         default: w = cw(OP_END, 1'b0, 1'b0);
      endcase
      return w;
   endfunction

endpackage

// File: design/capm_if.sv
// Valid/ready channel interfaces for the tick input and the motor result.
// Depends on capm_pkg for field widths.
interface capm_req_if;
   import capm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [RATE_W-1:0]  pitch_rate;
   logic signed [RATE_W-1:0]  roll_rate;
   logic signed [ACCEL_W-1:0] accel_pitch;
   logic signed [ACCEL_W-1:0] accel_roll;
   logic [STICK_W-1:0]        roll_stick;
   logic [STICK_W-1:0]        pitch_stick;
   logic [STICK_W-1:0]        arm_switch;

   modport source (output valid, pitch_rate, roll_rate, accel_pitch, accel_roll,
                   roll_stick, pitch_stick, arm_switch, input ready);
   modport sink   (input valid, pitch_rate, roll_rate, accel_pitch, accel_roll,
                   roll_stick, pitch_stick, arm_switch, output ready);
endinterface

interface capm_rsp_if;
   import capm_pkg::*;
   logic               valid;
   logic               ready;
   logic [PULSE_W-1:0] front_left;
   logic [PULSE_W-1:0] front_right;
   logic [PULSE_W-1:0] back_left;
   logic [PULSE_W-1:0] back_right;
   logic               armed;

   modport source (output valid, front_left, front_right, back_left, back_right,
                   armed, input ready);
   modport sink   (input valid, front_left, front_right, back_left, back_right,
                   armed, output ready);
endinterface

// File: design/capm_csr.sv
// APB-style register bank holding the loop gains, hover throttle and pulse limit.
// Depends on capm_pkg.
module capm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [capm_pkg::CSR_AW-1:0]   paddr,
   input  logic [capm_pkg::CSR_DW-1:0]   pwdata,
   output logic [capm_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready,
   output capm_pkg::cfg_type             cfg
);
   import capm_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_AW-1:2];
   assign wr     = psel && penable && pwrite;
   assign cfg    = cfg_ff;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_ANGLE_P: cfg_in.angle_p   = pwdata[GAIN_W-1:0];
            REG_ANGLE_I: cfg_in.angle_i   = pwdata[GAIN_W-1:0];
            REG_ANGLE_D: cfg_in.angle_d   = pwdata[GAIN_W-1:0];
            REG_RATE_P:  cfg_in.rate_p    = pwdata[GAIN_W-1:0];
            REG_RATE_I:  cfg_in.rate_i    = pwdata[GAIN_W-1:0];
            REG_RATE_D:  cfg_in.rate_d    = pwdata[GAIN_W-1:0];
            REG_HOVER:   cfg_in.hover     = pwdata[PULSE_W-1:0];
            REG_MAX:     cfg_in.max_pulse = pwdata[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_p   <= RST_ANGLE_P;
         cfg_ff.angle_i   <= RST_ANGLE_I;
         cfg_ff.angle_d   <= RST_ANGLE_D;
         cfg_ff.rate_p    <= RST_RATE_P;
         cfg_ff.rate_i    <= RST_RATE_I;
         cfg_ff.rate_d    <= RST_RATE_D;
         cfg_ff.hover     <= RST_HOVER;
         cfg_ff.max_pulse <= RST_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (idx)
         REG_ANGLE_P: prdata = CSR_DW'(cfg_ff.angle_p);
         REG_ANGLE_I: prdata = CSR_DW'(cfg_ff.angle_i);
         REG_ANGLE_D: prdata = CSR_DW'(cfg_ff.angle_d);
         REG_RATE_P:  prdata = CSR_DW'(cfg_ff.rate_p);
         REG_RATE_I:  prdata = CSR_DW'(cfg_ff.rate_i);
         REG_RATE_D:  prdata = CSR_DW'(cfg_ff.rate_d);
         REG_HOVER:   prdata = CSR_DW'(cfg_ff.hover);
         REG_MAX:     prdata = CSR_DW'(cfg_ff.max_pulse);
         default:     prdata = '0;
      endcase
   end

endmodule

// File: design/capm_seq.sv
// Microprogram sequencer: step counter over the control store, with the
// disarm jump and the output stall. Depends on capm_pkg.
module capm_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  capm_pkg::stat_type stat,
   output capm_pkg::ctrl_type ctrl,
   output logic               busy
);
   import capm_pkg::*;

   logic              run_ff, run_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ctrl_type          word;

   assign word = rom_word(step_ff);
   assign busy = run_ff;

   always_comb begin
      ctrl        = word;
      ctrl.active = run_ff;
   end

   // next step
   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      if (!run_ff) begin
         if (start) begin
            run_in  = 1'b1;
            step_in = '0;
         end
      end else if (word.op == OP_END) begin
         if (!stat.out_busy) begin
            run_in = 1'b0;
         end
      end else if (word.jump && stat.disarmed) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
      end
   end

endmodule

// File: design/capm_dp.sv
// Datapath: one shared 32x32 multiplier, accumulators, filter and PID state,
// motor mixer and the result register. Depends on capm_pkg.
module capm_dp #(
   parameter int FRAC_BITS      = 8,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  capm_pkg::req_item_type item,
   input  capm_pkg::ctrl_type     ctrl,
   input  capm_pkg::cfg_type      cfg,
   input  logic                   rsp_ready,
   output capm_pkg::stat_type     stat,
   output logic                   rsp_valid,
   output capm_pkg::rsp_item_type rsp_item
);
   import capm_pkg::*;

   localparam int F        = FRAC_BITS;
   localparam int G        = GAIN_FRAC_BITS;
   localparam int SP_W     = STICK_W + 1 + F;
   localparam int RECIP_SH = SP_W + 4;
   localparam longint RECIP_L = ((64'sd1 <<< RECIP_SH) + 9) / 10;
   localparam logic signed [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);
   localparam int I_SHIFT  = G + F - 5;
   localparam int SC_UP    = (F >= INT_FRAC) ? F - INT_FRAC : 0;
   localparam int SC_DN    = (F >= INT_FRAC) ? 1 : INT_FRAC - F;
   localparam logic signed [63:0] LIM_O = 64'sd400 <<< F;
   localparam logic signed [63:0] LIM_I = 64'sd800 <<< F;
   localparam int LOUT_W   = F + 11;
   localparam int MIX_W    = F + 14;
   localparam int S_W      = STATE_W + 2;

   // round to nearest, ties up: floor((x + half) / 2^n)
   function automatic logic signed [63:0] rsr(input logic signed [63:0] x, input int n);
      return (x + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic logic signed [63:0] sat64(input logic signed [63:0] x,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
      return (x < lo) ? lo : ((x > hi) ? hi : x);
   endfunction

   // integral from Q13 to the angle format
   function automatic logic signed [63:0] scale_int(input logic signed [STATE_W-1:0] v);
      if (F >= INT_FRAC) begin
         return 64'(v) <<< SC_UP;
      end
      return rsr(64'(v), SC_DN);
   endfunction

   function automatic logic [PULSE_W-1:0] motor(input logic signed [MIX_W-1:0] v,
                                                input logic [PULSE_W-1:0] upper);
      logic signed [MIX_W-1:0] lo;
      logic signed [MIX_W-1:0] hi;
      logic signed [MIX_W-1:0] c;
      lo = MIX_W'($signed({1'b0, PULSE_MIN})) <<< F;
      hi = MIX_W'($signed({1'b0, upper})) <<< F;
      c  = (v < lo) ? lo : ((v > hi) ? hi : v);
      return PULSE_W'(c >>> F);
   endfunction

   // tick inputs
   logic signed [RATE_W-1:0]  rate_ff[2], rate_in[2];
   logic signed [ACCEL_W-1:0] accel_ff[2], accel_in[2];
   logic [STICK_W-1:0]        stick_ff[2], stick_in[2];
   logic [STICK_W-1:0]        arm_ff, arm_in;
   // loop state
   logic signed [STATE_W-1:0] fused_ff[2], fused_in[2];
   logic signed [STATE_W-1:0] integ_ff[4], integ_in[4];
   logic signed [STATE_W-1:0] last_ff[4], last_in[4];
   logic [PULSE_W-1:0]        ramp_ff, ramp_in;
   logic                      armed_ff, armed_in;
   // working registers
   logic signed [63:0]        m_ff, m_in;
   logic signed [63:0]        a_ff, a_in;
   logic signed [S_W-1:0]     s_ff, s_in;
   logic signed [S_W-1:0]     q_ff, q_in;
   logic signed [STATE_W-1:0] err_ff, err_in;
   logic                      neg_ff, neg_in;
   logic signed [LOUT_W-1:0]  tgt_ff, tgt_in;
   logic signed [LOUT_W-1:0]  corr_ff[2], corr_in[2];
   // result
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_item_type              rsp_ff, rsp_in;

   logic                      ax;
   logic [1:0]                slot;
   logic [GAIN_W-1:0]         kp, ki, kd;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [63:0]        prod;
   logic signed [STICK_W+1:0] sp_diff;
   logic [STICK_W-1:0]        sp_mag;
   logic [SP_W-1:0]           sp_x;
   logic                      out_busy;
   logic [PULSE_W-1:0]        upper;
   logic signed [MIX_W-1:0]   thr, pc, rc;

   assign ax       = ctrl.axis;
   assign slot     = {ctrl.axis, ctrl.inner};
   assign kp       = ctrl.inner ? cfg.rate_p : cfg.angle_p;
   assign ki       = ctrl.inner ? cfg.rate_i : cfg.angle_i;
   assign kd       = ctrl.inner ? cfg.rate_d : cfg.angle_d;
   assign out_busy = rsp_valid_ff && !rsp_ready;

   assign stat.disarmed = (arm_ff < ARM_LEVEL);
   assign stat.out_busy = out_busy;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item      = rsp_ff;

   // stick setpoint magnitude, divided by ten through the reciprocal
   assign sp_diff = $signed({2'b00, stick_ff[ax]}) - $signed({2'b00, ARM_LEVEL});
   assign sp_mag  = sp_diff[STICK_W+1] ? STICK_W'(-sp_diff) : STICK_W'(sp_diff);
   assign sp_x    = (SP_W'(sp_mag) << F) + SP_W'(5);

   // mixer terms
   assign upper = (cfg.max_pulse < PULSE_MIN) ? PULSE_MIN : cfg.max_pulse;
   assign thr   = MIX_W'($signed({1'b0, ramp_ff})) <<< F;
   assign pc    = MIX_W'(corr_ff[0]);
   assign rc    = MIX_W'(corr_ff[1]);

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.op)
         OP_F_MUL_RATE: begin
            mul_a = MUL_W'(rate_ff[ax]);
            mul_b = DT_Q24;
         end
         OP_F_MUL_ALPHA: begin
            mul_a = MUL_W'(s_ff);
            mul_b = ALPHA_Q16;
         end
         OP_F_MUL_BETA: begin
            mul_a = MUL_W'(accel_ff[ax]);
            mul_b = BETA_Q16;
         end
         OP_SP_MUL: begin
            mul_a = $signed(MUL_W'(sp_x));
            mul_b = RECIP;
         end
         OP_MUL_P: begin
            mul_a = $signed(MUL_W'(kp));
            mul_b = MUL_W'(err_ff);
         end
         OP_P_STEP: begin
            mul_a = MUL_W'(err_ff) + MUL_W'(last_ff[slot]);
            mul_b = HALF_DT_Q24;
         end
         OP_MUL_I: begin
            mul_a = $signed(MUL_W'(ki));
            mul_b = MUL_W'(q_ff);
         end
         OP_INT_STEP: begin
            mul_a = $signed(MUL_W'(kd));
            mul_b = MUL_W'(err_ff) - MUL_W'(last_ff[slot]);
         end
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;

   // micro-op execution
   always_comb begin
      logic signed [63:0] raw;
      logic signed [63:0] spv;
      logic signed [63:0] lim;
      logic signed [63:0] res;
      raw = '0;
      spv = '0;
      lim = '0;
      res = '0;

      rate_in  = rate_ff;
      accel_in = accel_ff;
      stick_in = stick_ff;
      arm_in   = arm_ff;
      fused_in = fused_ff;
      integ_in = integ_ff;
      last_in  = last_ff;
      ramp_in  = ramp_ff;
      armed_in = armed_ff;
      m_in     = m_ff;
      a_in     = a_ff;
      s_in     = s_ff;
      q_in     = q_ff;
      err_in   = err_ff;
      neg_in   = neg_ff;
      tgt_in   = tgt_ff;
      corr_in  = corr_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      // capture the accepted item
      if (load) begin
         rate_in[0]  = item.pitch_rate;
         rate_in[1]  = item.roll_rate;
         accel_in[0] = item.accel_pitch;
         accel_in[1] = item.accel_roll;
         stick_in[0] = item.pitch_stick;
         stick_in[1] = item.roll_stick;
         arm_in      = item.arm_switch;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (ctrl.active) begin
         case (ctrl.op)
            OP_F_MUL_RATE, OP_F_MUL_ALPHA, OP_MUL_P, OP_MUL_I: begin
               m_in = prod;
            end
            OP_F_SUM: begin
               s_in = S_W'(64'(fused_ff[ax]) + rsr(m_ff, 24));
            end
            OP_F_MUL_BETA: begin
               a_in = m_ff;
               m_in = prod;
            end
            OP_F_WRITE: begin
               fused_in[ax] = STATE_W'(sat64(rsr(a_ff + m_ff, 16), S24_MIN, S24_MAX));
            end
            OP_ARM: begin
               if (arm_ff < ARM_LEVEL) begin
                  ramp_in  = PULSE_MIN;
                  armed_in = 1'b0;
                  for (int i = 0; i < 4; i++) begin
                     integ_in[i] = '0;
                     last_in[i]  = '0;
                  end
               end else begin
                  armed_in = 1'b1;
                  ramp_in  = (ramp_ff < cfg.hover) ? ramp_ff + 1'b1 : cfg.hover;
               end
            end
            OP_SP_MUL: begin
               m_in   = prod;
               neg_in = sp_diff[STICK_W+1];
            end
            OP_ERR: begin
               if (ctrl.inner) begin
                  raw = 64'(tgt_ff) - 64'(rate_ff[ax]);
               end else begin
                  spv = m_ff >>> RECIP_SH;
                  raw = (neg_ff ? -spv : spv) - 64'(fused_ff[ax]);
               end
               err_in = STATE_W'(sat64(raw, S24_MIN, S24_MAX));
            end
            OP_P_STEP: begin
               a_in = rsr(m_ff, G);
               m_in = prod;
            end
            OP_Q_STEP: begin
               q_in = S_W'(rsr(m_ff, 16));
            end
            OP_INT_STEP: begin
               raw = 64'(integ_ff[slot]) + rsr(m_ff, I_SHIFT);
               integ_in[slot] = STATE_W'(sat64(raw, -INT_LIM, INT_LIM));
               m_in = prod;
            end
            OP_D_STEP: begin
               // times 250 = 256 - 4 - 2
               m_in = (m_ff <<< 8) - (m_ff <<< 2) - (m_ff <<< 1);
               a_in = a_ff + scale_int(integ_ff[slot]);
            end
            OP_OUT_STEP: begin
               lim = ctrl.inner ? LIM_I : LIM_O;
               res = sat64(a_ff + rsr(m_ff, G), -lim, lim);
               last_in[slot] = err_ff;
               if (ctrl.inner) begin
                  corr_in[ax] = LOUT_W'(res);
               end else begin
                  tgt_in = LOUT_W'(res);
               end
            end
            OP_END: begin
               if (!out_busy) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.armed = armed_ff;
                  if (armed_ff) begin
                     rsp_in.front_left  = motor(thr + pc + rc, upper);
                     rsp_in.front_right = motor(thr + pc - rc, upper);
                     rsp_in.back_left   = motor(thr - pc + rc, upper);
                     rsp_in.back_right  = motor(thr - pc - rc, upper);
                  end else begin
                     rsp_in.front_left  = PULSE_MIN;
                     rsp_in.front_right = PULSE_MIN;
                     rsp_in.back_left   = PULSE_MIN;
                     rsp_in.back_right  = PULSE_MIN;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // control and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         fused_ff     <= '{default: '0};
         integ_ff     <= '{default: '0};
         last_ff      <= '{default: '0};
         ramp_ff      <= PULSE_MIN;
         armed_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fused_ff     <= fused_in;
         integ_ff     <= integ_in;
         last_ff      <= last_in;
         ramp_ff      <= ramp_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      rate_ff  <= rate_in;
      accel_ff <= accel_in;
      stick_ff <= stick_in;
      arm_ff   <= arm_in;
      m_ff     <= m_in;
      a_ff     <= a_in;
      s_ff     <= s_in;
      q_ff     <= q_in;
      err_ff   <= err_in;
      neg_ff   <= neg_in;
      tgt_ff   <= tgt_in;
      corr_ff  <= corr_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// File: design/cascaded_attitude_pid_mixer.sv
// Cascaded angle/rate PID attitude controller with a quadcopter motor mixer,
// one item per control tick. An armed tick runs 46 microprogram steps (filter,
// arm check, four PIDs, output), each through the single shared 32x32
// multiplier or adder stage, and the result is registered at the last step.
// A disarmed tick jumps from the arm check to the last step. If the previous
// result is still waiting for the consumer, the sequencer holds in its last
// step until it is taken. A new tick is accepted as soon as the sequencer is
// idle, even while the previous result is still held for the consumer.
// Configuration writes are taken at any time but belong between ticks. Top
// level: ties register bank, sequencer and datapath together.
// Depends on capm_pkg, capm_if, capm_csr, capm_seq and capm_dp.
module cascaded_attitude_pid_mixer #(
   parameter int FRAC_BITS      = 8,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   capm_req_if.sink                    req_if,
   capm_rsp_if.source                  rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [capm_pkg::CSR_AW-1:0] paddr,
   input  logic [capm_pkg::CSR_DW-1:0] pwdata,
   output logic [capm_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);
   import capm_pkg::*;

   cfg_type      cfg;
   ctrl_type     ctrl;
   stat_type     stat;
   req_item_type item;
   rsp_item_type rsp_item;
   logic         busy;
   logic         accept;
   logic         rsp_valid;

   assign req_if.ready = !busy;
   assign accept       = req_if.valid && req_if.ready;

   assign item.pitch_rate  = req_if.pitch_rate;
   assign item.roll_rate   = req_if.roll_rate;
   assign item.accel_pitch = req_if.accel_pitch;
   assign item.accel_roll  = req_if.accel_roll;
   assign item.roll_stick  = req_if.roll_stick;
   assign item.pitch_stick = req_if.pitch_stick;
   assign item.arm_switch  = req_if.arm_switch;

   assign rsp_if.valid       = rsp_valid;
   assign rsp_if.front_left  = rsp_item.front_left;
   assign rsp_if.front_right = rsp_item.front_right;
   assign rsp_if.back_left   = rsp_item.back_left;
   assign rsp_if.back_right  = rsp_item.back_right;
   assign rsp_if.armed       = rsp_item.armed;

   capm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   capm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .stat  (stat),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   capm_dp #(
      .FRAC_BITS      (FRAC_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .item      (item),
      .ctrl      (ctrl),
      .cfg       (cfg),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

// File: design/capm_checker.sv
// Port-level checks of the attitude mixer, bound to the top level.
// Depends on capm_pkg and cascaded_attitude_pid_mixer.
module capm_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [capm_pkg::PULSE_W-1:0] front_left,
   input logic [capm_pkg::PULSE_W-1:0] front_right,
   input logic [capm_pkg::PULSE_W-1:0] back_left,
   input logic [capm_pkg::PULSE_W-1:0] back_right,
   input logic                         armed
);
   import capm_pkg::*;

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while a tick was in work");

   // disarmed result idles every motor
   a_disarmed_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !armed |-> front_left == PULSE_MIN && front_right == PULSE_MIN
                              && back_left == PULSE_MIN && back_right == PULSE_MIN)
      else $error("disarmed item with a motor above idle");

   // mixer lower clamp
   a_motor_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> front_left >= PULSE_MIN && front_right >= PULSE_MIN
                    && back_left >= PULSE_MIN && back_right >= PULSE_MIN)
      else $error("motor pulse below idle");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(front_left)
         && $stable(front_right) && $stable(back_left) && $stable(back_right)
         && $stable(armed))
      else $error("result changed while stalled");

endmodule

bind cascaded_attitude_pid_mixer capm_checker u_capm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .front_left  (rsp_if.front_left),
   .front_right (rsp_if.front_right),
   .back_left   (rsp_if.back_left),
   .back_right  (rsp_if.back_right),
   .armed       (rsp_if.armed)
);
